// File: src/wwa_pkg.sv
// Shared opcodes, state encoding and widths for the wide-word ALU.
package wwa_pkg;
  localparam int W = 256;
  localparam int LW = 64;
  localparam int NL = W / LW;
  localparam int SW = 8;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_LT = 5'd5, OP_GT = 5'd6, OP_SLT = 5'd7, OP_SGT = 5'd8, OP_EQ = 5'd9,
    OP_IS_ZERO = 5'd10, OP_AND = 5'd11, OP_OR = 5'd12, OP_XOR = 5'd13,
    OP_NOT = 5'd14, OP_SHL = 5'd15, OP_SHR = 5'd16
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOVE = 5'b00010,
    S_STEP = 5'b00100,
    S_PASS = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  typedef struct packed {
    logic start;
    logic [4:0] op;
    logic mode;
  } ctl_t;
endpackage

// File: src/wwa_serial.sv
// Limb-serial engine: one 64-bit limb per cycle; mul and divide take one limb pass per bit.
module wwa_serial (
  input  logic clk,
  input  logic rst,
  input  wwa_pkg::ctl_t ctl,
  input  logic [wwa_pkg::W-1:0] x,
  input  logic [wwa_pkg::W-1:0] y,
  output logic done,
  output logic [wwa_pkg::W-1:0] res
);
  import wwa_pkg::*;

  state_t state;
  logic [4:0] op;
  logic mode, carry, lt, eqf, zdiv, rtop;
  logic [W-1:0] a, b, acc, r, d;
  logic [1:0] li, ls;
  logic [5:0] bs;
  logic [SW-1:0] step;
  logic [1:0] last_li, ld_ls;
  logic [SW-1:0] last_step;
  logic last_limb, sign_flip, swap, ld_shift, ld_big;
  logic [LW-1:0] al, bl, xa, yb, cmp_p, cmp_q, lo_nb, hi_nb;
  logic [LW-1:0] shl_limb, shr_limb, add_a, add_b, limb_out;
  logic [LW:0] sum, diff;

  function automatic logic [W-1:0] rot(input logic [W-1:0] v, input logic m);
    return m ? v : {v[LW-1:0], v[W-1:LW]};
  endfunction

  assign last_li = mode ? 2'd0 : 2'(NL - 1);
  assign last_step = mode ? SW'(LW - 1) : SW'(W - 1);
  assign last_limb = (li == last_li);
  assign al = a[LW-1:0];
  assign bl = b[LW-1:0];

  assign ld_shift = (ctl.op == OP_SHL) || (ctl.op == OP_SHR);
  assign ld_big = ctl.mode ? (x[LW-1:0] >= 64'(LW)) : (x[W-1:8] != '0);
  assign ld_ls = (ld_shift && !ld_big) ? x[7:6] : 2'd0;

  always_comb begin
    add_a = (op == OP_MUL) ? acc[LW-1:0] : al;
    add_b = bl;
    if (op == OP_SUB) add_b = ~bl;
    else if (op == OP_MUL && !a[0]) add_b = '0;
    sum = {1'b0, add_a} + {1'b0, add_b} + {{LW{1'b0}}, carry};
    diff = {1'b0, r[LW-1:0]} - {1'b0, bl} - {{LW{1'b0}}, carry};

    sign_flip = (op == OP_SLT || op == OP_SGT) && last_limb;
    swap = (op == OP_GT || op == OP_SGT);
    xa = al ^ {sign_flip, {(LW-1){1'b0}}};
    yb = (op == OP_IS_ZERO) ? '0 : (bl ^ {sign_flip, {(LW-1){1'b0}}});
    cmp_p = swap ? yb : xa;
    cmp_q = swap ? xa : yb;

    lo_nb = (li == 2'd0) ? '0 : b[W-1:W-LW];
    hi_nb = last_limb ? '0 : b[2*LW-1:LW];
    shl_limb = (bl << bs) | (lo_nb >> (7'(LW) - {1'b0, bs}));
    shr_limb = (bl >> bs) | (hi_nb << (7'(LW) - {1'b0, bs}));

    unique case (op)
      OP_AND: limb_out = al & bl;
      OP_OR:  limb_out = al | bl;
      OP_XOR: limb_out = al ^ bl;
      OP_NOT: limb_out = ~al;
      OP_SHL: limb_out = shl_limb;
      OP_SHR: limb_out = shr_limb;
      default: limb_out = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            op <= ctl.op;
            mode <= ctl.mode;
            a <= ctl.mode ? {{(W-LW){1'b0}}, x[LW-1:0]} : x;
            b <= (ld_shift && ld_big) ? '0 :
                 (ctl.mode ? {{(W-LW){1'b0}}, y[LW-1:0]} : y);
            acc <= '0;
            r <= '0;
            d <= '0;
            carry <= (ctl.op == OP_SUB);
            lt <= 1'b0;
            eqf <= 1'b1;
            rtop <= 1'b0;
            li <= '0;
            step <= '0;
            zdiv <= ctl.mode ? (y[LW-1:0] == '0) : (y == '0);
            ls <= ld_ls;
            bs <= x[5:0];
            if (ctl.op == OP_DIV || ctl.op == OP_MOD) state <= S_STEP;
            else if (ld_ls != 2'd0) state <= S_MOVE;
            else state <= S_PASS;
          end
        end
        S_MOVE: begin
          b <= (op == OP_SHL) ? (b << LW) : (b >> LW);
          ls <= ls - 2'd1;
          if (ls == 2'd1) state <= S_PASS;
        end
        S_STEP: begin
          rtop <= mode ? r[LW-1] : r[W-1];
          r <= {r[W-2:0], mode ? a[LW-1] : a[W-1]};
          a <= a << 1;
          carry <= 1'b0;
          state <= S_PASS;
        end
        S_PASS: begin
          li <= last_limb ? 2'd0 : li + 2'd1;
          unique case (op)
            OP_ADD, OP_SUB: begin
              acc <= rot({acc[W-1:LW], sum[LW-1:0]}, mode);
              carry <= sum[LW];
              a <= rot(a, mode);
              b <= rot(b, mode);
              if (last_limb) state <= S_FIN;
            end
            OP_MUL: begin
              acc <= rot({acc[W-1:LW], sum[LW-1:0]}, mode);
              carry <= sum[LW] && !last_limb;
              b <= last_limb ? (rot(b, mode) << 1) : rot(b, mode);
              if (last_limb) begin
                a <= a >> 1;
                step <= step + 1'b1;
                if (step == last_step) state <= S_FIN;
              end
            end
            OP_DIV, OP_MOD: begin
              d <= rot({d[W-1:LW], diff[LW-1:0]}, mode);
              carry <= diff[LW];
              b <= rot(b, mode);
              if (last_limb) begin
                if (rtop || !diff[LW]) r <= rot({d[W-1:LW], diff[LW-1:0]}, mode);
                else r <= rot(r, mode);
                acc <= {acc[W-2:0], rtop || !diff[LW]};
                step <= step + 1'b1;
                state <= (step == last_step) ? S_FIN : S_STEP;
              end else begin
                r <= rot(r, mode);
              end
            end
            OP_LT, OP_GT, OP_SLT, OP_SGT, OP_EQ, OP_IS_ZERO: begin
              if (cmp_p != cmp_q) lt <= (cmp_p < cmp_q);
              eqf <= eqf && (xa == yb);
              a <= rot(a, mode);
              b <= rot(b, mode);
              if (last_limb) state <= S_FIN;
            end
            default: begin
              acc <= rot({acc[W-1:LW], limb_out}, mode);
              a <= rot(a, mode);
              b <= rot(b, mode);
              if (last_limb) state <= S_FIN;
            end
          endcase
        end
        S_FIN: begin
          done <= 1'b1;
          unique case (op)
            OP_LT, OP_GT, OP_SLT, OP_SGT: res <= {{(W-1){1'b0}}, lt};
            OP_EQ, OP_IS_ZERO: res <= {{(W-1){1'b0}}, eqf};
            OP_DIV: res <= zdiv ? '0 : (mode ? {{(W-LW){1'b0}}, acc[LW-1:0]} : acc);
            OP_MOD: res <= zdiv ? '0 : (mode ? {{(W-LW){1'b0}}, r[LW-1:0]} : r);
            default: res <= mode ? {{(W-LW){1'b0}}, acc[LW-1:0]} : acc;
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: src/wide_word_alu_256.sv
// Top level of the wide-word ALU: handshake, mode register and output hold.
// Add, sub, compares, logic ops and unused opcodes make a single pass over the limbs;
// shifts first move b by whole limbs in S_MOVE, up to 3 limbs in 256-bit mode;
// mul and div, mod make one limb pass per operand bit (256 or 64 bits by mode).
// Throughput: one item at a time; the next is taken in the cycle after the result is taken.
// Reset: rst synchronous active high clears the engine, valid flags and word_mode.
module wide_word_alu_256 (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [4:0] opcode,
  input  logic [63:0] x_limb0, x_limb1, x_limb2, x_limb3,
  input  logic [63:0] y_limb0, y_limb1, y_limb2, y_limb3,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output logic out_valid,
  input  logic out_ready,
  output logic [63:0] result_limb0, result_limb1, result_limb2, result_limb3
);
  import wwa_pkg::*;

  logic word_mode, busy, done;
  ctl_t ctl;
  logic [W-1:0] res;

  assign in_ready = !busy;
  assign ctl = '{start: in_valid && !busy, op: opcode, mode: word_mode};

  wwa_serial u_ser (
    .clk, .rst, .ctl,
    .x({x_limb3, x_limb2, x_limb1, x_limb0}),
    .y({y_limb3, y_limb2, y_limb1, y_limb0}),
    .done, .res
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      word_mode <= 1'b0;
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) word_mode <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_valid && !busy) busy <= 1'b1;
      if (done) begin
        out_valid <= 1'b1;
        {result_limb3, result_limb2, result_limb1, result_limb0} <= res;
      end
      if (out_valid && out_ready) busy <= 1'b0;
    end
  end
endmodule
